// File: src/dts_pkg.sv
// Shared types, constants and calendar tables for the date/time to seconds converter.
// Used by dts_days, date_time_to_seconds, dts_checker and the testbench; depends on nothing else.
`default_nettype none

package dts_pkg;

	typedef struct packed {
		logic [13:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
	} dts_in_t;

	typedef struct packed {
		logic        valid_res;
		logic [31:0] seconds_since_epoch;
		logic [25:0] minutes_since_epoch;
	} dts_out_t;

	// Day count plus the time of day, as it leaves the calendar stages.
	typedef struct packed {
		logic        valid;
		logic        ok;
		logic [15:0] days;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} dts_day_t;

	localparam int unsigned MONTHS      = 12;
	localparam int unsigned MAX_HOUR    = 23;
	localparam int unsigned MAX_MINUTE  = 59;
	localparam int unsigned MAX_SECOND  = 59;
	localparam int unsigned YEAR_FOLD   = 100;
	localparam int unsigned DAYS_YEAR   = 365;
	localparam int unsigned HOURS_DAY   = 24;
	localparam int unsigned SECS_MIN    = 60;
	// floor(year / 100) == (year * RECIP_100) >> RECIP_SHIFT for every 14-bit year.
	localparam int unsigned RECIP_100   = 5243;
	localparam int unsigned RECIP_SHIFT = 19;

	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// Days in the year before the first of the given month.
	function automatic logic [8:0] days_before(input logic [3:0] mon, input logic leap);
		logic [8:0] d;
		case (mon)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		if (leap && mon > 4'd2) begin
			d = d + 9'd1;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// File: src/dts_days.sv
// Calendar stages s1..s4: folds the year, checks the date and time, and counts days.
// Depends on dts_pkg.
`default_nettype none

module dts_days (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                item_valid,
	input  wire dts_pkg::dts_in_t    item,
	output dts_pkg::dts_day_t        stage
);
	import dts_pkg::*;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [26:0] prod;
	logic [7:0]  q_s1;
	logic        time_ok_s1, mon_ok_s1;
	logic [13:0] year_s1;
	logic [3:0]  mon_s1, mon_s2;
	logic [7:0]  day_s1, day_s2;
	logic [4:0]  hour_s1, hour_s2, hour_s3, hour_s4;
	logic [5:0]  min_s1, min_s2, min_s3, min_s4;
	logic [5:0]  sec_s1, sec_s2, sec_s3, sec_s4;
	logic        time_ok_s2, mon_ok_s2;
	logic [6:0]  yy_s2;
	logic        leap;
	logic [4:0]  mlen;
	logic        ok_s3, ok_s4;
	logic [15:0] dyear_s3;
	logic [8:0]  dmon_s3;
	logic [4:0]  day_s3;
	logic [15:0] days_s4;

	assign prod = 27'(item.year) * 27'(RECIP_100);
	assign leap = (yy_s2[1:0] == 2'b00);
	assign mlen = month_len(mon_s2, leap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: quotient of year by 100 and the range checks that need no year.
			q_s1       <= prod[26:RECIP_SHIFT];
			year_s1    <= item.year;
			time_ok_s1 <= (item.hour <= 8'(MAX_HOUR)) && (item.minute <= 8'(MAX_MINUTE))
			              && (item.second <= 8'(MAX_SECOND));
			mon_ok_s1  <= (item.month != 8'd0) && (item.month <= 8'(MONTHS));
			mon_s1     <= item.month[3:0];
			day_s1     <= item.day;
			hour_s1    <= item.hour[4:0];
			min_s1     <= item.minute[5:0];
			sec_s1     <= item.second[5:0];

			// s2: year modulo 100.
			yy_s2      <= 7'(year_s1 - 14'(q_s1) * 14'(YEAR_FOLD));
			time_ok_s2 <= time_ok_s1;
			mon_ok_s2  <= mon_ok_s1;
			mon_s2     <= mon_s1;
			day_s2     <= day_s1;
			hour_s2    <= hour_s1;
			min_s2     <= min_s1;
			sec_s2     <= sec_s1;

			// s3: day check, days of the earlier years and of the earlier months.
			// Years before yy hold (yy + 3) / 4 leap days, counting year 0 itself.
			ok_s3    <= time_ok_s2 && mon_ok_s2 && (day_s2 != 8'd0) && (day_s2 <= 8'(mlen));
			dyear_s3 <= 16'(yy_s2) * 16'(DAYS_YEAR) + 16'((8'(yy_s2) + 8'd3) >> 2);
			dmon_s3  <= days_before(mon_s2, leap);
			day_s3   <= day_s2[4:0];
			hour_s3  <= hour_s2;
			min_s3   <= min_s2;
			sec_s3   <= sec_s2;

			// s4: total day count.
			ok_s4   <= ok_s3;
			days_s4 <= dyear_s3 + 16'(dmon_s3) + 16'(day_s3) - 16'd1;
			hour_s4 <= hour_s3;
			min_s4  <= min_s3;
			sec_s4  <= sec_s3;
		end
	end

	assign stage.valid  = valid_s4;
	assign stage.ok     = ok_s4;
	assign stage.days   = days_s4;
	assign stage.hour   = hour_s4;
	assign stage.minute = min_s4;
	assign stage.second = sec_s4;

endmodule

`default_nettype wire

// File: src/date_time_to_seconds.sv
// Top level of the date/time to seconds converter: time-of-day stages and output register.
// Depends on dts_pkg and dts_days.
//
// Usage: a transaction on the item channel carries one calendar date and time; each
// gives exactly one transaction on the result channel, in order. Only the year modulo
// 100 counts, and every fourth folded year is a leap year. A legal date and time gives
// valid_res = 1 with seconds and whole minutes since 2000-01-01 00:00:00; an illegal
// one gives valid_res = 0 and both counts zero.
// An accepted transaction passes in order through seven register stages (year fold, year
// remainder, calendar lookup, day sum, hours, minutes, seconds), which move together;
// throughput is one transaction per cycle while the receiver does not stall.
// When the receiver stalls with the output register full, the whole pipeline holds
// and item_ready falls in the same cycle; nothing is dropped or repeated.
// Reset clears all stage valid bits; no clearing pass is needed.
`default_nettype none

module date_time_to_seconds (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire dts_pkg::dts_in_t  item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output dts_pkg::dts_out_t      result
);
	import dts_pkg::*;

	logic        en;
	dts_day_t    stage;
	logic        valid_s5, valid_s6, valid_s7;
	logic        ok_s5, ok_s6;
	logic [19:0] hours_s5;
	logic [5:0]  min_s5, sec_s5, sec_s6;
	logic [25:0] mins_s6;
	dts_out_t    out_s7;

	assign en         = !valid_s7 || result_ready;
	assign item_ready = en;

	dts_days u_days (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.item_valid (item_valid),
		.item       (item),
		.stage      (stage)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s5 <= stage.valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s5    <= stage.ok;
			hours_s5 <= 20'(stage.days) * 20'(HOURS_DAY) + 20'(stage.hour);
			min_s5   <= stage.minute;
			sec_s5   <= stage.second;

			ok_s6   <= ok_s5;
			mins_s6 <= 26'(hours_s5) * 26'(SECS_MIN) + 26'(min_s5);
			sec_s6  <= sec_s5;

			// The minute count is already the seconds divided by 60.
			out_s7.valid_res           <= ok_s6;
			out_s7.seconds_since_epoch <= ok_s6 ? (32'(mins_s6) * 32'(SECS_MIN) + 32'(sec_s6))
			                                    : 32'd0;
			out_s7.minutes_since_epoch <= ok_s6 ? mins_s6 : 26'd0;
		end
	end

	assign result_valid = valid_s7;
	assign result       = out_s7;

endmodule

`default_nettype wire

// File: src/dts_checker.sv
// Port-level checker for date_time_to_seconds, bound to the top level below.
// Depends on dts_pkg.
`default_nettype none

module dts_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              result_valid,
	input  wire logic              result_ready,
	input  wire dts_pkg::dts_out_t result
);
	import dts_pkg::*;

	logic [31:0] min_x60;

	assign min_x60 = 32'(result.minutes_since_epoch) * 32'(SECS_MIN);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result_valid dropped before the transaction completed");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result payload changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.valid_res |->
		result.seconds_since_epoch == 32'd0 && result.minutes_since_epoch == 26'd0)
		else $error("illegal date gave nonzero counts");

	a_minutes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.valid_res |->
		min_x60 <= result.seconds_since_epoch &&
		result.seconds_since_epoch - min_x60 < 32'(SECS_MIN))
		else $error("minute count does not match second count");

endmodule

bind date_time_to_seconds dts_checker u_dts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

// File: tb/stamp_checker.sv
// Checker for the date/time to seconds converter: predicts each result from the item channel
// and compares it with the result channel. Depends on dts_pkg for the payload types.
`timescale 1ns / 1ps

module stamp_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  dts_pkg::dts_in_t  item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  dts_pkg::dts_out_t result,
	output int                fail_count,
	output int                pending_cnt,
	output int                result_cnt,
	output int                legal_cnt
);
	import dts_pkg::*;

	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int REPORT_LIMIT = 10;

	dts_out_t pending_stamps [$];
	int mismatches = 0;
	int results_seen = 0;
	int legal_seen = 0;

	function automatic int unsigned days_in_month(input int unsigned mon, input logic leap);
		int unsigned len;
		len = (mon >= 1 && mon <= MONTHS) ? MONTH_DAYS[mon - 1] : 31;
		if (leap && mon == 2) begin
			len = 29;
		end
		return len;
	endfunction

	function automatic dts_out_t convert_stamp(input dts_in_t x);
		int unsigned yy;
		int unsigned mon;
		int unsigned dd;
		int unsigned hh;
		int unsigned mm;
		int unsigned ss;
		int unsigned days;
		int unsigned total;
		int unsigned m;
		logic leap;
		logic legal;
		dts_out_t r;
		yy = x.year % YEAR_FOLD;
		mon = x.month;
		dd = x.day;
		hh = x.hour;
		mm = x.minute;
		ss = x.second;
		// Folded years that are multiples of four are leap years, century years included.
		leap = (yy % 4) == 0;
		legal = mon >= 1 && mon <= MONTHS && dd >= 1 && dd <= days_in_month(mon, leap)
			&& hh <= MAX_HOUR && mm <= MAX_MINUTE && ss <= MAX_SECOND;
		r = '0;
		if (legal) begin
			days = 0;
			if (yy != 0) begin
				days = DAYS_YEAR * yy + (yy - 1) / 4 + 1;
			end
			for (m = 1; m < mon; m++) begin
				days += days_in_month(m, leap);
			end
			days += dd - 1;
			total = ((days * HOURS_DAY + hh) * 60 + mm) * SECS_MIN + ss;
			r.valid_res = 1'b1;
			r.seconds_since_epoch = total;
			r.minutes_since_epoch = 26'(total / SECS_MIN);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		dts_out_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (result.valid_res) begin
					legal_seen++;
				end
				if (pending_stamps.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%0t: result transaction %0d arrived with nothing expected",
							$realtime, results_seen);
					end
				end else begin
					want = pending_stamps.pop_front();
					if (result.valid_res !== want.valid_res
						|| result.seconds_since_epoch !== want.seconds_since_epoch
						|| result.minutes_since_epoch !== want.minutes_since_epoch) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: result %0d expected valid=%0b sec=%0d min=%0d",
								$realtime, results_seen, want.valid_res,
								want.seconds_since_epoch, want.minutes_since_epoch);
							$display("%0t: result %0d actual   valid=%0b sec=%0d min=%0d",
								$realtime, results_seen, result.valid_res,
								result.seconds_since_epoch, result.minutes_since_epoch);
						end
					end
				end
			end
			if (item_valid && item_ready) begin
				pending_stamps.push_back(convert_stamp(item));
			end
		end
		fail_count <= mismatches;
		pending_cnt <= pending_stamps.size();
		result_cnt <= results_seen;
		legal_cnt <= legal_seen;
	end

endmodule

// File: tb/tb_date_time_to_seconds.sv
// Top of the date/time to seconds testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on dts_pkg, date_time_to_seconds and stamp_checker.
`timescale 1ns / 1ps

module tb_date_time_to_seconds;
	import dts_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	dts_in_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	dts_out_t result;

	int fail_count;
	int pending_cnt;
	int result_cnt;
	int legal_cnt;
	int idle_cycles = 0;

	int stall_left = 0;
	int stall_mode = 0;

	dts_in_t directed_stamps [$];

	always #6 clk = ~clk;

	date_time_to_seconds dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	stamp_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.pending_cnt  (pending_cnt),
		.result_cnt   (result_cnt),
		.legal_cnt    (legal_cnt)
	);

	function automatic dts_in_t make_stamp(input int unsigned y, input int unsigned mo,
		input int unsigned d, input int unsigned h, input int unsigned mi, input int unsigned s);
		dts_in_t x;
		x.year = 14'(y);
		x.month = 8'(mo);
		x.day = 8'(d);
		x.hour = 8'(h);
		x.minute = 8'(mi);
		x.second = 8'(s);
		return x;
	endfunction

	function automatic dts_in_t random_stamp();
		dts_in_t x;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0:       x.year = 14'($urandom_range(0, 163) * 100);
			1:       x.year = 14'($urandom_range(2000, 2099));
			default: x.year = 14'($urandom_range(0, 16383));
		endcase
		x.month = 8'($urandom_range(1, 12));
		x.day = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 28)) : 8'($urandom_range(29, 31));
		x.hour = 8'($urandom_range(0, 23));
		x.minute = 8'($urandom_range(0, 59));
		x.second = 8'($urandom_range(0, 59));
		if (kind >= 70 && kind < 80) begin
			// Ends of the month and of the day.
			x.day = 8'($urandom_range(28, 31));
			x.hour = $urandom_range(0, 1) ? 8'd23 : 8'd0;
			x.minute = $urandom_range(0, 1) ? 8'd59 : 8'd0;
			x.second = $urandom_range(0, 1) ? 8'd59 : 8'd0;
		end else if (kind >= 80 && kind < 92) begin
			// An otherwise plausible stamp with one field out of range.
			case ($urandom_range(0, 4))
				0:       x.month = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(13, 255));
				1:       x.day = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(32, 255));
				2:       x.hour = 8'($urandom_range(24, 255));
				3:       x.minute = 8'($urandom_range(60, 255));
				default: x.second = 8'($urandom_range(60, 255));
			endcase
		end else if (kind >= 92) begin
			x = dts_in_t'({$urandom, $urandom});
		end
		return x;
	endfunction

	task automatic push_stamp(input dts_in_t x);
		item <= x;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	// Receiver: stretches of always-ready, hard stalls and coin-flip readiness.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(1, 30);
			result_ready <= 1'b1;
		end else begin
			stall_left <= stall_left - 1;
			case (stall_mode)
				0:       result_ready <= 1'b1;
				1:       result_ready <= (stall_left > 12) ? 1'b1 : 1'b0;
				default: result_ready <= $urandom_range(0, 1);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int total_items;
		int sent;
		int burst;
		int gap;
		dts_in_t next_item;

		directed_stamps.push_back(make_stamp(2000, 1, 1, 0, 0, 0));
		directed_stamps.push_back(make_stamp(2099, 12, 31, 23, 59, 59));
		directed_stamps.push_back(make_stamp(2000, 2, 29, 12, 30, 30));
		directed_stamps.push_back(make_stamp(2100, 2, 29, 0, 0, 1));
		directed_stamps.push_back(make_stamp(2004, 2, 29, 1, 2, 3));
		directed_stamps.push_back(make_stamp(2001, 2, 29, 1, 2, 3));
		directed_stamps.push_back(make_stamp(2003, 2, 28, 23, 59, 59));
		directed_stamps.push_back(make_stamp(2010, 0, 10, 5, 5, 5));
		directed_stamps.push_back(make_stamp(2010, 13, 10, 5, 5, 5));
		directed_stamps.push_back(make_stamp(2010, 255, 10, 5, 5, 5));
		directed_stamps.push_back(make_stamp(2010, 1, 0, 5, 5, 5));
		directed_stamps.push_back(make_stamp(2010, 1, 32, 5, 5, 5));
		directed_stamps.push_back(make_stamp(2010, 4, 31, 5, 5, 5));
		directed_stamps.push_back(make_stamp(2010, 4, 30, 5, 5, 5));
		directed_stamps.push_back(make_stamp(2010, 7, 255, 5, 5, 5));
		directed_stamps.push_back(make_stamp(2010, 7, 4, 24, 0, 0));
		directed_stamps.push_back(make_stamp(2010, 7, 4, 255, 0, 0));
		directed_stamps.push_back(make_stamp(2010, 7, 4, 0, 60, 0));
		directed_stamps.push_back(make_stamp(2010, 7, 4, 0, 255, 0));
		directed_stamps.push_back(make_stamp(2010, 7, 4, 0, 0, 60));
		directed_stamps.push_back(make_stamp(2010, 7, 4, 0, 0, 255));
		directed_stamps.push_back(make_stamp(9999, 12, 31, 23, 59, 59));
		directed_stamps.push_back(make_stamp(16383, 12, 31, 23, 59, 59));
		directed_stamps.push_back(make_stamp(0, 3, 1, 0, 0, 0));
		directed_stamps.push_back(make_stamp(16383, 255, 255, 255, 255, 255));

		total_items = directed_stamps.size() + RANDOM_ITEMS;
		sent = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (sent < total_items) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && sent < total_items) begin
				next_item = (sent < directed_stamps.size()) ? directed_stamps[sent] : random_stamp();
				push_stamp(next_item);
				sent++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item_valid <= 1'b0;

		do @(posedge clk); while (pending_cnt != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d date/time transactions, %0d legal and %0d rejected, with stalls",
			result_cnt, legal_cnt, result_cnt - legal_cnt);
		$display("on both channels; directed cases hit field limits, leap Februaries and century years.");
		if (fail_count == 0 && pending_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: sim.f
src/dts_pkg.sv
src/dts_days.sv
src/date_time_to_seconds.sv
src/dts_checker.sv
tb/stamp_checker.sv
tb/tb_date_time_to_seconds.sv
